FILE: hw/rtl/tnes_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// tnes_pkg
// Shared types and constants for the timed note event scheduler.
// ============================================================================
package tnes_pkg;

    // default table size
    localparam int SLOTS_DEF = 32;

    // argument limits for a push
    localparam logic [7:0] CHANNEL_MAX  = 8'd15;
    localparam logic [7:0] NOTE_MAX     = 8'd127;
    localparam logic [7:0] VELOCITY_MAX = 8'd127;

    // operation codes (code 3 is unused and reports invalid)
    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_NEAR = 2'd2
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2
    } status_t;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SCAN   = 2'd1,
        S_DRAIN  = 2'd2,
        S_FINISH = 2'd3
    } state_t;

    // one stored event
    typedef struct packed {
        logic [47:0] evt_time;
        logic [31:0] duration;
        logic [3:0]  channel;
        logic [6:0]  note;
        logic [6:0]  velocity;
    } slot_t;

    // controller to datapath
    typedef struct packed {
        logic start;   // latch the input word, clear scan results
        logic step;    // read one slot, advance the scan address
        logic finish;  // commit the table update, load the result word
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;  // scan address is at the last slot
        logic out_busy;   // result register full and stalled
    } sts_t;

endpackage

FILE: hw/rtl/tnes_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// tnes_ctrl
// Sequencer: accept a word, scan every slot, drain the read pipe, then hand
// the result to the output register once it is free.
// ============================================================================
module tnes_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  tnes_pkg::sts_t  sts,
    output tnes_pkg::cmd_t  cmd
);

    tnes_pkg::state_t state_reg;
    tnes_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tnes_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            tnes_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = tnes_pkg::S_SCAN;
                end
            end
            tnes_pkg::S_SCAN:
            begin
                cmd.step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = tnes_pkg::S_DRAIN;
                end
            end
            tnes_pkg::S_DRAIN:
            begin
                // last slot is evaluated in this cycle
                state_next = tnes_pkg::S_FINISH;
            end
            tnes_pkg::S_FINISH:
            begin
                if (!sts.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = tnes_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tnes_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/tnes_dp.sv
`timescale 1ns / 1ps
// ============================================================================
// tnes_dp
// Slot table, scan pipeline, selection registers and the result register.
// ============================================================================
module tnes_dp
#(
    parameter int SLOTS = tnes_pkg::SLOTS_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  tnes_pkg::cmd_t  cmd,
    output tnes_pkg::sts_t  sts,
    input  logic [1:0]      op,
    input  logic [47:0]     event_time,
    input  logic [7:0]      channel_in,
    input  logic [7:0]      note_in,
    input  logic [7:0]      velocity_in,
    input  logic [31:0]     duration_in,
    input  logic [31:0]     window_in,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [1:0]      status,
    output logic            found,
    output logic            near_flag,
    output logic [47:0]     event_time_out,
    output logic [31:0]     duration_out,
    output logic [3:0]      channel_out,
    output logic [6:0]      note_out,
    output logic [6:0]      velocity_out
);

    localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // slot storage
    tnes_pkg::slot_t     mem [SLOTS];
    logic [SLOTS-1:0]    used_reg;
    logic [SLOTS-1:0]    used_next;

    // latched input word
    logic [1:0]          op_reg;
    logic [47:0]         now_reg;
    logic [47:0]         lo_reg;
    logic [48:0]         hi_reg;
    logic                args_ok_reg;
    tnes_pkg::slot_t     new_slot_reg;

    // scan pipe
    logic [ADDR_W-1:0]   addr_reg;
    logic                pv_reg;
    tnes_pkg::slot_t     rd_reg;
    logic                rd_used_reg;
    logic [ADDR_W-1:0]   rd_idx_reg;

    // selection
    logic                have_reg;
    logic                have_next;
    logic [ADDR_W-1:0]   pick_reg;
    tnes_pkg::slot_t     best_reg;
    logic                near_reg;
    logic                near_next;
    logic                take;
    logic                near_hit;

    // result register
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [1:0]          status_reg;
    logic                found_reg;
    logic                near_flag_reg;
    tnes_pkg::slot_t     res_reg;
    logic [1:0]          res_status;
    logic                res_found;

    logic                args_ok;
    logic                commit_push;
    logic                commit_pop;

    // push argument range check
    assign args_ok = (channel_in <= tnes_pkg::CHANNEL_MAX)
                  && (note_in <= tnes_pkg::NOTE_MAX)
                  && (velocity_in <= tnes_pkg::VELOCITY_MAX);

    // status to controller
    assign sts.scan_last = (addr_reg == ADDR_W'(SLOTS - 1));
    assign sts.out_busy  = out_valid_reg && out_stall;

    // per-slot evaluation of the word read last cycle
    always_comb
    begin
        case (op_reg)
            tnes_pkg::OP_PUSH:
            begin
                take = !rd_used_reg && !have_reg;
            end
            tnes_pkg::OP_POP:
            begin
                take = rd_used_reg && (rd_reg.evt_time <= now_reg)
                    && (!have_reg || (rd_reg.evt_time < best_reg.evt_time));
            end
            default:
            begin
                take = 1'b0;
            end
        endcase
        near_hit = (op_reg == tnes_pkg::OP_NEAR) && rd_used_reg
                && (rd_reg.evt_time >= lo_reg)
                && ({1'b0, rd_reg.evt_time} <= hi_reg);
    end

    assign have_next = cmd.start ? 1'b0 : ((pv_reg && take) ? 1'b1 : have_reg);
    assign near_next = cmd.start ? 1'b0 : ((pv_reg && near_hit) ? 1'b1 : near_reg);

    // table update at finish
    assign commit_push = (op_reg == tnes_pkg::OP_PUSH) && args_ok_reg && have_reg;
    assign commit_pop  = (op_reg == tnes_pkg::OP_POP) && have_reg;

    always_comb
    begin
        used_next = used_reg;
        if (cmd.finish && commit_push)
        begin
            used_next[pick_reg] = 1'b1;
        end
        else if (cmd.finish && commit_pop)
        begin
            used_next[pick_reg] = 1'b0;
        end
    end

    // result word
    always_comb
    begin
        res_found = 1'b0;
        case (op_reg)
            tnes_pkg::OP_PUSH:
            begin
                if (!args_ok_reg)
                begin
                    res_status = tnes_pkg::ST_INVALID;
                end
                else if (have_reg)
                begin
                    res_status = tnes_pkg::ST_OK;
                end
                else
                begin
                    res_status = tnes_pkg::ST_FULL;
                end
            end
            tnes_pkg::OP_POP:
            begin
                res_status = tnes_pkg::ST_OK;
                res_found  = have_reg;
            end
            tnes_pkg::OP_NEAR:
            begin
                res_status = tnes_pkg::ST_OK;
            end
            default:
            begin
                res_status = tnes_pkg::ST_INVALID;
            end
        endcase
    end

    assign out_valid_next = cmd.finish ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            addr_reg      <= '0;
            pv_reg        <= 1'b0;
            have_reg      <= 1'b0;
            near_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg      <= used_next;
            pv_reg        <= cmd.step;
            have_reg      <= have_next;
            near_reg      <= near_next;
            out_valid_reg <= out_valid_next;
            if (cmd.start)
            begin
                addr_reg <= '0;
            end
            else if (cmd.step && !sts.scan_last)
            begin
                addr_reg <= addr_reg + 1'b1;
            end
        end
    end

    // payload registers and slot memory
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg                <= op;
            now_reg               <= event_time;
            hi_reg                <= {1'b0, event_time} + 49'(window_in);
            lo_reg                <= (event_time >= 48'(window_in))
                                   ? (event_time - 48'(window_in)) : '0;
            args_ok_reg           <= args_ok;
            new_slot_reg.evt_time <= event_time;
            new_slot_reg.duration <= duration_in;
            new_slot_reg.channel  <= channel_in[3:0];
            new_slot_reg.note     <= note_in[6:0];
            new_slot_reg.velocity <= velocity_in[6:0];
        end
        if (cmd.step)
        begin
            rd_reg      <= mem[addr_reg];
            rd_used_reg <= used_reg[addr_reg];
            rd_idx_reg  <= addr_reg;
        end
        if (pv_reg && take)
        begin
            pick_reg <= rd_idx_reg;
            best_reg <= rd_reg;
        end
        if (cmd.finish && commit_push)
        begin
            mem[pick_reg] <= new_slot_reg;
        end
        if (cmd.finish)
        begin
            status_reg    <= res_status;
            found_reg     <= res_found;
            near_flag_reg <= (op_reg == tnes_pkg::OP_NEAR) && near_reg;
            res_reg       <= res_found ? best_reg : '0;
        end
    end

    // outputs
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign found          = found_reg;
    assign near_flag      = near_flag_reg;
    assign event_time_out = res_reg.evt_time;
    assign duration_out   = res_reg.duration;
    assign channel_out    = res_reg.channel;
    assign note_out       = res_reg.note;
    assign velocity_out   = res_reg.velocity;

endmodule

FILE: hw/rtl/timed_note_event_scheduler.sv
`timescale 1ns / 1ps
// ============================================================================
// timed_note_event_scheduler
// Table of note events: push, pop earliest due event, near-onset query.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall) carries one operation word: op,
//   event_time and the push or query arguments. A word is taken when
//   in_valid is high and in_stall is low.
//   Output channel (out_valid / out_stall) returns one result word per
//   operation: status, found, near_flag and the popped event's fields.
//   Every operation scans all SLOTS entries through the single memory read
//   port, one read per cycle. No new word is taken until the result of the
//   current one has been loaded into the output register.
//   A result waiting in the output register does not block the next word;
//   its scan runs, and its result is held back until the receiver takes the
//   earlier one. in_stall stays high while a word is in work.
//   Reset marks every slot free; slot contents need no clearing.
// ============================================================================
module timed_note_event_scheduler
#(
    parameter int SLOTS = tnes_pkg::SLOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [47:0] event_time,
    input  logic [7:0]  channel_in,
    input  logic [7:0]  note_in,
    input  logic [7:0]  velocity_in,
    input  logic [31:0] duration_in,
    input  logic [31:0] window_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        found,
    output logic        near_flag,
    output logic [47:0] event_time_out,
    output logic [31:0] duration_out,
    output logic [3:0]  channel_out,
    output logic [6:0]  note_out,
    output logic [6:0]  velocity_out
);

    tnes_pkg::cmd_t cmd;
    tnes_pkg::sts_t sts;

    // sequencer
    tnes_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // table and result path
    tnes_dp #(.SLOTS(SLOTS)) u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .op             (op),
        .event_time     (event_time),
        .channel_in     (channel_in),
        .note_in        (note_in),
        .velocity_in    (velocity_in),
        .duration_in    (duration_in),
        .window_in      (window_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .found          (found),
        .near_flag      (near_flag),
        .event_time_out (event_time_out),
        .duration_out   (duration_out),
        .channel_out    (channel_out),
        .note_out       (note_out),
        .velocity_out   (velocity_out)
    );

endmodule

FILE: hw/rtl/tnes_chk.sv
`timescale 1ns / 1ps
// ============================================================================
// tnes_chk
// Port-level checks for the timed note event scheduler, bound to the top.
// ============================================================================
module tnes_chk
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  status,
    input  logic        found,
    input  logic        near_flag,
    input  logic [47:0] event_time_out,
    input  logic [31:0] duration_out,
    input  logic [3:0]  channel_out,
    input  logic [6:0]  note_out,
    input  logic [6:0]  velocity_out
);

    // a stalled result word stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(status) && $stable(found)
            && $stable(event_time_out) && $stable(near_flag))
        else $error("stalled result word changed");

    // block is busy right after taking a word
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second word taken during a scan");

    // a found event comes only with ok status and no near flag
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> status == tnes_pkg::ST_OK && !near_flag)
        else $error("found flag with bad status");

    // event fields are zero unless an event was removed
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> event_time_out == '0 && duration_out == '0
            && channel_out == '0 && note_out == '0 && velocity_out == '0)
        else $error("event fields nonzero without a removed event");

endmodule

bind timed_note_event_scheduler tnes_chk u_chk (.*);

FILE: verif/tnes_tb_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// tnes_tb_pkg
// Word types and scoreboard for the timed note event scheduler bench.
// ============================================================================
// The scoreboard keeps its own copy of the slot table. Each accepted input
// word updates that copy and queues the result word it should produce.
// Result words from the block are checked in order against that queue.
// ============================================================================
package tnes_tb_pkg;

    import tnes_pkg::*;

    // op code 3 has no operation behind it and must report invalid
    localparam logic [1:0]  OP_UNUSED = 2'd3;
    localparam logic [47:0] TIME_MAX  = 48'hFFFF_FFFF_FFFF;

    // one operation word on the input channel
    typedef struct {
        logic [1:0]  op;
        logic [47:0] evt_time;
        logic [7:0]  channel;
        logic [7:0]  note;
        logic [7:0]  velocity;
        logic [31:0] duration;
        logic [31:0] window;
    } sched_word_t;

    // one result word on the output channel
    typedef struct {
        logic [1:0]  status;
        logic        found;
        logic        near_flag;
        logic [47:0] evt_time;
        logic [31:0] duration;
        logic [3:0]  channel;
        logic [6:0]  note;
        logic [6:0]  velocity;
    } sched_result_t;

    function automatic logic [47:0] rand48();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        return v[47:0];
    endfunction

    class note_table_sb;

        bit          slot_busy [SLOTS_DEF];
        bit [47:0]   slot_at   [SLOTS_DEF];
        bit [31:0]   slot_len  [SLOTS_DEF];
        bit [3:0]    slot_chan [SLOTS_DEF];
        bit [6:0]    slot_key  [SLOTS_DEF];
        bit [6:0]    slot_vel  [SLOTS_DEF];

        sched_result_t due_q[$];

        int errors;
        int words_seen;
        int stored_cnt;
        int full_cnt;
        int invalid_cnt;
        int popped_cnt;
        int empty_pop_cnt;
        int near_hit_cnt;

        function new();
            foreach (slot_busy[k])
                slot_busy[k] = 1'b0;
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        function int fill_level();
            int n;
            n = 0;
            foreach (slot_busy[k])
                if (slot_busy[k])
                    n++;
            return n;
        endfunction

        // time of a random occupied slot, 0 when the table is empty
        function logic [47:0] any_stored_time();
            int n;
            int pick;
            n = fill_level();
            if (n == 0)
                return '0;
            pick = $urandom_range(0, n - 1);
            foreach (slot_busy[k])
            begin
                if (slot_busy[k])
                begin
                    if (pick == 0)
                        return slot_at[k];
                    pick--;
                end
            end
            return '0;
        endfunction

        // update the table copy for one accepted word, queue its result
        function void note_input(sched_word_t w);
            sched_result_t r;
            int            sel;
            logic [47:0]   gap;
            r = '{default: '0};
            sel = -1;
            words_seen++;
            case (w.op)
                OP_PUSH:
                begin
                    if (w.channel > CHANNEL_MAX || w.note > NOTE_MAX ||
                        w.velocity > VELOCITY_MAX)
                    begin
                        r.status = ST_INVALID;
                        invalid_cnt++;
                    end
                    else
                    begin
                        // lowest free slot
                        foreach (slot_busy[k])
                            if (sel < 0 && !slot_busy[k])
                                sel = k;
                        if (sel < 0)
                        begin
                            r.status = ST_FULL;
                            full_cnt++;
                        end
                        else
                        begin
                            slot_busy[sel] = 1'b1;
                            slot_at[sel]   = w.evt_time;
                            slot_len[sel]  = w.duration;
                            slot_chan[sel] = w.channel[3:0];
                            slot_key[sel]  = w.note[6:0];
                            slot_vel[sel]  = w.velocity[6:0];
                            r.status = ST_OK;
                            stored_cnt++;
                        end
                    end
                end
                OP_POP:
                begin
                    // earliest due slot; strict compare keeps the lowest index on ties
                    foreach (slot_busy[k])
                        if (slot_busy[k] && slot_at[k] <= w.evt_time)
                            if (sel < 0 || slot_at[k] < slot_at[sel])
                                sel = k;
                    r.status = ST_OK;
                    if (sel >= 0)
                    begin
                        r.found    = 1'b1;
                        r.evt_time = slot_at[sel];
                        r.duration = slot_len[sel];
                        r.channel  = slot_chan[sel];
                        r.note     = slot_key[sel];
                        r.velocity = slot_vel[sel];
                        slot_busy[sel] = 1'b0;
                        popped_cnt++;
                    end
                    else
                        empty_pop_cnt++;
                end
                OP_NEAR:
                begin
                    r.status = ST_OK;
                    foreach (slot_busy[k])
                    begin
                        if (slot_busy[k])
                        begin
                            gap = (slot_at[k] > w.evt_time) ? slot_at[k] - w.evt_time
                                                            : w.evt_time - slot_at[k];
                            if (gap <= {16'd0, w.window})
                                r.near_flag = 1'b1;
                        end
                    end
                    if (r.near_flag)
                        near_hit_cnt++;
                end
                default:
                begin
                    r.status = ST_INVALID;
                    invalid_cnt++;
                end
            endcase
            due_q.push_back(r);
        endfunction

        function void cmp_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
            if (exp_v !== act_v)
            begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        // compare one result word against the oldest queued one
        function void check_result(sched_result_t act);
            sched_result_t ex;
            if (due_q.size() == 0)
            begin
                $error("result word arrived with nothing pending");
                errors++;
                return;
            end
            ex = due_q.pop_front();
            cmp_field("status",         ex.status,    act.status);
            cmp_field("found",          ex.found,     act.found);
            cmp_field("near_flag",      ex.near_flag, act.near_flag);
            cmp_field("event_time_out", ex.evt_time,  act.evt_time);
            cmp_field("duration_out",   ex.duration,  act.duration);
            cmp_field("channel_out",    ex.channel,   act.channel);
            cmp_field("note_out",       ex.note,      act.note);
            cmp_field("velocity_out",   ex.velocity,  act.velocity);
        endfunction

    endclass

endpackage

FILE: verif/tb_timed_note_event_scheduler.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_timed_note_event_scheduler
// Self-checking bench for the timed note event scheduler.
// ============================================================================
// A short directed sequence covers field extremes, invalid pushes, the unused
// op code, pops with nothing due, tie breaking and near-window edges. Random
// words follow in four handshake phases (no idling, sender gaps, receiver
// stalls, both), alternating fill-heavy and drain-heavy stretches so the
// table runs full and empty. Every result word is checked against the
// scoreboard's own copy of the slot table.
// ============================================================================
module tb_timed_note_event_scheduler;

    import tnes_pkg::*;
    import tnes_tb_pkg::*;

    localparam int CYCLE_LIMIT     = 800000;
    localparam int WORDS_PER_PHASE = 332;
    localparam int STRETCH_LEN     = 60;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [1:0]  op          = '0;
    logic [47:0] event_time  = '0;
    logic [7:0]  channel_in  = '0;
    logic [7:0]  note_in     = '0;
    logic [7:0]  velocity_in = '0;
    logic [31:0] duration_in = '0;
    logic [31:0] window_in   = '0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [1:0]  status;
    logic        found;
    logic        near_flag;
    logic [47:0] event_time_out;
    logic [31:0] duration_out;
    logic [3:0]  channel_out;
    logic [6:0]  note_out;
    logic [6:0]  velocity_out;

    int          send_gap_pct  = 0;
    int          recv_stall_pct = 0;
    logic [47:0] base_time     = '0;

    note_table_sb sb = new();

    timed_note_event_scheduler i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .event_time     (event_time),
        .channel_in     (channel_in),
        .note_in        (note_in),
        .velocity_in    (velocity_in),
        .duration_in    (duration_in),
        .window_in      (window_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .found          (found),
        .near_flag      (near_flag),
        .event_time_out (event_time_out),
        .duration_out   (duration_out),
        .channel_out    (channel_out),
        .note_out       (note_out),
        .velocity_out   (velocity_out)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // result monitor and receiver stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{status, found, near_flag, event_time_out,
                              duration_out, channel_out, note_out, velocity_out});
        out_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);
    end

    // watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

    // present one word, hold it until taken, then log it
    task automatic send_word(sched_word_t w);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= w.op;
        event_time  <= w.evt_time;
        channel_in  <= w.channel;
        note_in     <= w.note;
        velocity_in <= w.velocity;
        duration_in <= w.duration;
        window_in   <= w.window;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(w);
    endtask

    task automatic send_op(logic [1:0] o, logic [47:0] t, logic [7:0] ch, logic [7:0] nt,
                           logic [7:0] vel, logic [31:0] dur, logic [31:0] win);
        sched_word_t w;
        w = '{o, t, ch, nt, vel, dur, win};
        send_word(w);
    endtask

    // hold the sender off until every pending result is back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // random word; times cluster around base_time or stored times so pops
    // and near queries actually land on slots
    function automatic sched_word_t random_word(int push_pct, int pop_pct);
        sched_word_t w;
        int          pick;
        logic [47:0] st;
        w.op       = OP_NEAR;
        w.evt_time = rand48();
        w.channel  = 8'($urandom());
        w.note     = 8'($urandom());
        w.velocity = 8'($urandom());
        w.duration = $urandom();
        w.window   = $urandom();
        st   = sb.any_stored_time();
        pick = $urandom_range(0, 99);
        if (pick < 3)
            w.op = OP_UNUSED;
        else if (pick < push_pct)
        begin
            w.op       = OP_PUSH;
            w.channel  = 8'($urandom_range(0, 15));
            w.note     = 8'($urandom_range(0, 127));
            w.velocity = 8'($urandom_range(0, 127));
            case ($urandom_range(0, 19))
                0: w.channel  = 8'($urandom_range(16, 255));
                1: w.note     = 8'($urandom_range(128, 255));
                2: w.velocity = 8'($urandom_range(128, 255));
                default: ;
            endcase
            case ($urandom_range(0, 19))
                0:       w.evt_time = '0;
                1:       w.evt_time = TIME_MAX - $urandom_range(0, 3);
                2, 3:    ;
                default: w.evt_time = base_time + $urandom_range(0, 2000);
            endcase
            case ($urandom_range(0, 9))
                0:       w.duration = '0;
                1:       w.duration = '1;
                default: ;
            endcase
        end
        else if (pick < push_pct + pop_pct)
        begin
            w.op = OP_POP;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: w.evt_time = st + $urandom_range(0, 2);
                4:          w.evt_time = st - 1;
                5, 6:       w.evt_time = base_time + $urandom_range(0, 2000);
                7:          w.evt_time = TIME_MAX;
                8:          w.evt_time = '0;
                default:    ;
            endcase
        end
        else
        begin
            w.op = OP_NEAR;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: w.evt_time = st + $urandom_range(0, 80) - 40;
                5:             w.evt_time = base_time + $urandom_range(0, 2000);
                6:             w.evt_time = '0;
                7:             w.evt_time = TIME_MAX;
                default:       ;
            endcase
            case ($urandom_range(0, 9))
                0:          w.window = '0;
                1:          w.window = '1;
                2, 3, 4, 5: w.window = $urandom_range(0, 50);
                6, 7:       w.window = $urandom_range(0, 2000);
                default:    ;
            endcase
        end
        return w;
    endfunction

    // alternate fill-heavy and drain-heavy stretches
    task automatic run_random(int n);
        bit filling;
        filling = 1'b0;
        for (int i = 0; i < n; i++)
        begin
            if (i % STRETCH_LEN == 0)
            begin
                filling   = !filling;
                base_time = rand48();
                if (base_time > TIME_MAX - 48'd10000)
                    base_time = TIME_MAX - 48'd10000;
            end
            if (filling)
                send_word(random_word(75, 10));
            else
                send_word(random_word(20, 60));
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, unused op, field extremes, invalid pushes
        send_op(OP_POP,    TIME_MAX, 8'h00, 8'h00, 8'h00, 32'h0, 32'h0);
        send_op(OP_NEAR,   '0,       8'h00, 8'h00, 8'h00, 32'h0, '1);
        send_op(OP_UNUSED, '0,       8'h00, 8'h00, 8'h00, 32'h0, 32'h0);
        send_op(OP_PUSH,   '0,       8'd0,  8'd0,  8'd0,  32'h0, 32'h0);
        send_op(OP_PUSH,   TIME_MAX, 8'd15, 8'd127, 8'd127, '1,  32'h0);
        send_op(OP_PUSH,   48'd77,   8'd16, 8'd10, 8'd10, 32'd5, 32'h0);
        send_op(OP_PUSH,   48'd77,   8'hFF, 8'hFF, 8'hFF, 32'd5, 32'h0);
        send_op(OP_PUSH,   48'd77,   8'd3,  8'd128, 8'd10, 32'd5, 32'h0);
        send_op(OP_PUSH,   48'd77,   8'd3,  8'd10, 8'd128, 32'd5, 32'h0);

        // near window edges: exact hit, one short, exactly reached
        send_op(OP_NEAR,   TIME_MAX, 8'h00, 8'h00, 8'h00, 32'h0, 32'd0);
        send_op(OP_NEAR,   48'd1000, 8'h00, 8'h00, 8'h00, 32'h0, 32'd999);
        send_op(OP_NEAR,   48'd1000, 8'h00, 8'h00, 8'h00, 32'h0, 32'd1000);

        // equal times go out lowest slot first; not-yet-due stays put
        send_op(OP_PUSH,   48'd500,  8'd1,  8'd60, 8'd90, 32'd11, 32'h0);
        send_op(OP_PUSH,   48'd500,  8'd2,  8'd61, 8'd91, 32'd22, 32'h0);
        send_op(OP_POP,    48'd499,  8'h00, 8'h00, 8'h00, 32'h0, 32'h0);
        send_op(OP_POP,    48'd499,  8'h00, 8'h00, 8'h00, 32'h0, 32'h0);
        send_op(OP_POP,    48'd500,  8'h00, 8'h00, 8'h00, 32'h0, 32'h0);
        send_op(OP_POP,    48'd500,  8'h00, 8'h00, 8'h00, 32'h0, 32'h0);
        send_op(OP_POP,    TIME_MAX - 1, 8'h00, 8'h00, 8'h00, 32'h0, 32'h0);
        send_op(OP_POP,    TIME_MAX, 8'h00, 8'h00, 8'h00, 32'h0, 32'h0);
        send_op(OP_NEAR,   '0,       8'h00, 8'h00, 8'h00, 32'h0, '1);
        send_op(OP_UNUSED, TIME_MAX, 8'hFF, 8'hFF, 8'hFF, '1,    '1);

        // four handshake phases
        for (int ph = 0; ph < 4; ph++)
        begin
            drain_results();
            case (ph)
                0:       begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_gap_pct = 48; recv_stall_pct = 0;  end
                2:       begin send_gap_pct = 0;  recv_stall_pct = 48; end
                default: begin send_gap_pct = 7;  recv_stall_pct = 7;  end
            endcase
            run_random(WORDS_PER_PHASE);
        end

        drain_results();
        repeat (SLOTS_DEF + 8) @(posedge clk);

        $display("Ran %0d words: %0d events stored, %0d rejected as full, %0d invalid.",
                 sb.words_seen, sb.stored_cnt, sb.full_cnt, sb.invalid_cnt);
        $display("Popped %0d events, %0d pops found nothing due, %0d near queries hit.",
                 sb.popped_cnt, sb.empty_pop_cnt, sb.near_hit_cnt);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
